@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the cooling degree window tracker.
// Self-contained; included by files that carry concurrent assertions.
// The bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ sv/cdwt_pkg.sv @@
// Package for the cooling degree window tracker: field widths and defaults.
// No dependencies; used by cdwt_mem and the top level.
package cdwt_pkg;

    localparam int WINDOW_DEFAULT = 100;

    localparam int TEMP_W   = 11;
    localparam int EXCESS_W = 12;
    localparam int TOTAL_W  = 32;
    // Wide enough for min + max - 2*ref with every 11-bit pattern allowed
    localparam int DIFF_W   = 14;

    localparam logic signed [TEMP_W-1:0] REF_RESET = 11'sd260;
    localparam logic signed [TEMP_W-1:0] TEMP_POS_MAX = 11'sh3FF;
    localparam logic signed [TEMP_W-1:0] TEMP_NEG_MIN = 11'sh400;

endpackage

@@ sv/cdwt_mem.sv @@
// Sample ring store: one write port, one read port, registered read data.
// Depends on cdwt_pkg for the sample width.
module cdwt_mem #(
    parameter int WINDOW = cdwt_pkg::WINDOW_DEFAULT,
    parameter int PTR_W  = $clog2(WINDOW)
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [PTR_W-1:0]                    wr_addr,
    input  logic signed [cdwt_pkg::TEMP_W-1:0]  wr_data,
    input  logic                                rd_en,
    input  logic [PTR_W-1:0]                    rd_addr,
    output logic signed [cdwt_pkg::TEMP_W-1:0]  rd_data
);

    logic signed [cdwt_pkg::TEMP_W-1:0] mem [WINDOW];
    logic signed [cdwt_pkg::TEMP_W-1:0] rd_data_reg;

    // Write a sample
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read: rd_data follows in the cycle after rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/cooling_degree_window_tracker_top.sv @@
// Cooling degree window tracker, top level. Uses cdwt_pkg, cdwt_mem, assert_macros.svh.
// A store transaction leaves busy low; the next item may follow at once.
// An evaluation of a full window raises busy through ST_SCAN, ST_CALC and ST_ACC, with one
// read of the sample memory per entry, and strobes done in the same cycle that busy falls.
// An evaluation before the window is full leaves busy low and strobes nothing.
// rst_n clears pointer, full flag, total and ref_temp (to 26.0 degrees); samples stay undefined.
`include "assert_macros.svh"

module cooling_degree_window_tracker_top #(
    parameter int WINDOW = cdwt_pkg::WINDOW_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    op,
    input  logic signed [cdwt_pkg::TEMP_W-1:0]      temperature,
    input  logic                                    sample_valid,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic signed [cdwt_pkg::TEMP_W-1:0]      cfg_data,
    output logic                                    done,
    output logic [cdwt_pkg::EXCESS_W-1:0]           degree_excess,
    output logic [cdwt_pkg::TOTAL_W-1:0]            running_total,
    output logic signed [cdwt_pkg::TEMP_W-1:0]      window_min,
    output logic signed [cdwt_pkg::TEMP_W-1:0]      window_max
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(WINDOW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_ACC
    } state_t;

    state_t                                  state_reg;
    logic [PTR_W-1:0]                        wr_ptr_reg;
    logic                                    full_reg;
    logic signed [cdwt_pkg::TEMP_W-1:0]      ref_reg;
    logic [CNT_W-1:0]                        cnt_reg;
    logic                                    data_vld_reg;
    logic signed [cdwt_pkg::TEMP_W-1:0]      min_reg;
    logic signed [cdwt_pkg::TEMP_W-1:0]      max_reg;
    logic [cdwt_pkg::EXCESS_W-1:0]           excess_reg;
    logic [cdwt_pkg::TOTAL_W-1:0]            total_reg;
    logic                                    done_reg;
    logic [cdwt_pkg::EXCESS_W-1:0]           out_excess_reg;
    logic [cdwt_pkg::TOTAL_W-1:0]            out_total_reg;
    logic signed [cdwt_pkg::TEMP_W-1:0]      out_min_reg;
    logic signed [cdwt_pkg::TEMP_W-1:0]      out_max_reg;

    logic                                    accept;
    logic                                    mem_wr_en;
    logic                                    mem_rd_en;
    logic [PTR_W-1:0]                        mem_rd_addr;
    logic signed [cdwt_pkg::TEMP_W-1:0]      mem_rd_data;
    logic signed [cdwt_pkg::DIFF_W-1:0]      diff;
    logic [cdwt_pkg::TOTAL_W:0]              sum;
    logic [cdwt_pkg::TOTAL_W-1:0]            total_next;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign mem_wr_en = accept && !op && sample_valid;

    // Issue one read per entry while the counter runs
    assign mem_rd_en   = (state_reg == ST_SCAN) && (cnt_reg != CNT_END);
    assign mem_rd_addr = cnt_reg[PTR_W-1:0];

    // Excess over twice the reference, signed before the clamp
    assign diff = cdwt_pkg::DIFF_W'(min_reg) + cdwt_pkg::DIFF_W'(max_reg)
                  - (cdwt_pkg::DIFF_W'(ref_reg) <<< 1);

    // Saturating add into the running total
    assign sum        = {1'b0, total_reg} + (cdwt_pkg::TOTAL_W + 1)'(excess_reg);
    assign total_next = sum[cdwt_pkg::TOTAL_W] ? {cdwt_pkg::TOTAL_W{1'b1}}
                                               : sum[cdwt_pkg::TOTAL_W-1:0];

    cdwt_mem #(
        .WINDOW (WINDOW),
        .PTR_W  (PTR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (temperature),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Hold the reference temperature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= cdwt_pkg::REF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ref_reg <= cfg_data;
        end
    end

    // Advance the write pointer and mark the window full on the first wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            full_reg   <= 1'b0;
        end
        else if (mem_wr_en)
        begin
            if (wr_ptr_reg == PTR_LAST)
            begin
                wr_ptr_reg <= '0;
                full_reg   <= 1'b1;
            end
            else
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Evaluation sequencer with registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            data_vld_reg   <= 1'b0;
            min_reg        <= cdwt_pkg::TEMP_POS_MAX;
            max_reg        <= cdwt_pkg::TEMP_NEG_MIN;
            excess_reg     <= '0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
            out_excess_reg <= '0;
            out_total_reg  <= '0;
            out_min_reg    <= '0;
            out_max_reg    <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            data_vld_reg <= mem_rd_en;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op && full_reg)
                    begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= '0;
                        min_reg   <= cdwt_pkg::TEMP_POS_MAX;
                        max_reg   <= cdwt_pkg::TEMP_NEG_MIN;
                    end
                end
                ST_SCAN:
                begin
                    if (mem_rd_en)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    // Fold each returned sample into the extremes
                    if (data_vld_reg)
                    begin
                        if (mem_rd_data < min_reg)
                        begin
                            min_reg <= mem_rd_data;
                        end
                        if (mem_rd_data > max_reg)
                        begin
                            max_reg <= mem_rd_data;
                        end
                    end
                    if (data_vld_reg && (cnt_reg == CNT_END))
                    begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    excess_reg <= (diff > 0) ? diff[cdwt_pkg::EXCESS_W-1:0] : '0;
                    state_reg  <= ST_ACC;
                end
                ST_ACC:
                begin
                    total_reg      <= total_next;
                    out_excess_reg <= excess_reg;
                    out_total_reg  <= total_next;
                    out_min_reg    <= min_reg;
                    out_max_reg    <= max_reg;
                    done_reg       <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign degree_excess = out_excess_reg;
    assign running_total = out_total_reg;
    assign window_min    = out_min_reg;
    assign window_max    = out_max_reg;

    `ASSERT_CLK(a_done_after_acc, clk, rst_n, done |-> $past(state_reg == ST_ACC), "done without accumulate step")
    `ASSERT_NEVER_CLK(a_no_write_busy, clk, rst_n, mem_wr_en && busy, "sample write during scan")
    `ASSERT_CLK(a_done_needs_full, clk, rst_n, done |-> full_reg, "result from a window not yet full")
    `ASSERT_CLK(a_early_eval_idle, clk, rst_n, (accept && op && !full_reg) |=> !busy, "evaluation of partial window started a scan")
    `ASSERT_CLK(a_total_monotone, clk, rst_n, (state_reg == ST_ACC) |=> (total_reg >= $past(total_reg)), "running total decreased")

endmodule

@@ bench/tb_cooling_degree_window_tracker_top.sv @@
// Self-checking bench for the cooling degree window tracker top level.
// Depends on cdwt_pkg and the RTL under sv/; a directed table is followed by random phases.
`timescale 1ns / 100ps

module tb_cooling_degree_window_tracker_top;

    localparam int WINDOW      = cdwt_pkg::WINDOW_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = WINDOW + 8;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 112;

    typedef enum logic { OP_STORE = 1'b0, OP_EVAL = 1'b1 } op_t;
    typedef enum logic { ROW_ITEM = 1'b0, ROW_REF = 1'b1 } row_kind_t;

    typedef struct packed {
        logic [cdwt_pkg::EXCESS_W-1:0]          excess;
        logic [cdwt_pkg::TOTAL_W-1:0]           total;
        logic signed [cdwt_pkg::TEMP_W-1:0]     lo;
        logic signed [cdwt_pkg::TEMP_W-1:0]     hi;
    } excess_report_t;

    typedef struct {
        row_kind_t                              kind;
        op_t                                    op;
        logic signed [cdwt_pkg::TEMP_W-1:0]     temp;
        logic                                   valid;
        int                                     reps;
        bit                                     typed;
        excess_report_t                         want;
    } stim_row_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   start = 1'b0;
    logic                                   busy;
    logic                                   op = OP_STORE;
    logic signed [cdwt_pkg::TEMP_W-1:0]     temperature = '0;
    logic                                   sample_valid = 1'b0;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic signed [cdwt_pkg::TEMP_W-1:0]     cfg_data = '0;
    logic                                   done;
    logic [cdwt_pkg::EXCESS_W-1:0]          degree_excess;
    logic [cdwt_pkg::TOTAL_W-1:0]           running_total;
    logic signed [cdwt_pkg::TEMP_W-1:0]     window_min;
    logic signed [cdwt_pkg::TEMP_W-1:0]     window_max;

    // Shadow copy of the tracker state
    logic signed [cdwt_pkg::TEMP_W-1:0]     shadow_ring [WINDOW];
    int                                     shadow_wptr = 0;
    bit                                     shadow_full = 1'b0;
    logic [cdwt_pkg::TOTAL_W-1:0]           shadow_total = '0;
    logic signed [cdwt_pkg::TEMP_W-1:0]     shadow_ref = cdwt_pkg::REF_RESET;

    excess_report_t             pending_reports [$];
    stim_row_t                  directed_rows [$];

    int                         mismatch_count = 0;
    int                         reports_checked = 0;
    int                         items_sent = 0;
    int                         ref_writes = 0;
    int                         cycle_count = 0;

    cooling_degree_window_tracker_top #(
        .WINDOW         (WINDOW)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .temperature    (temperature),
        .sample_valid   (sample_valid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .degree_excess  (degree_excess),
        .running_total  (running_total),
        .window_min     (window_min),
        .window_max     (window_max)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare each strobed report with the oldest prediction
    always @(posedge clk)
    begin
        excess_report_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
                report_mismatch("report strobed with none pending");
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                check_field("degree_excess", 32'(degree_excess), 32'(want.excess));
                check_field("running_total", running_total, want.total);
                check_field("window_min", 32'(window_min), 32'(want.lo));
                check_field("window_max", 32'(window_max), 32'(want.hi));
            end
        end
    end

    // Advance the shadow state by one transaction; return 1 when a report follows
    function automatic bit track_window(op_t op_i,
                                        logic signed [cdwt_pkg::TEMP_W-1:0] t,
                                        logic v,
                                        output excess_report_t rep);
        int                             lo;
        int                             hi;
        int                             diff;
        int                             k;
        logic [cdwt_pkg::TOTAL_W:0]     sum;
        rep = '0;
        if (op_i == OP_STORE)
        begin
            if (v)
            begin
                shadow_ring[shadow_wptr] = t;
                if (shadow_wptr == WINDOW - 1)
                begin
                    shadow_wptr = 0;
                    shadow_full = 1'b1;
                end
                else
                    shadow_wptr++;
            end
            return 1'b0;
        end
        if (!shadow_full)
            return 1'b0;
        lo = shadow_ring[0];
        hi = lo;
        for (k = 1; k < WINDOW; k++)
        begin
            if (shadow_ring[k] < lo)
                lo = shadow_ring[k];
            if (shadow_ring[k] > hi)
                hi = shadow_ring[k];
        end
        diff = lo + hi - 2 * shadow_ref;
        rep.excess = (diff > 0) ? cdwt_pkg::EXCESS_W'(diff) : '0;
        sum = {1'b0, shadow_total} + (cdwt_pkg::TOTAL_W + 1)'(rep.excess);
        shadow_total = sum[cdwt_pkg::TOTAL_W] ? '1 : sum[cdwt_pkg::TOTAL_W-1:0];
        rep.total = shadow_total;
        rep.lo = cdwt_pkg::TEMP_W'(lo);
        rep.hi = cdwt_pkg::TEMP_W'(hi);
        return 1'b1;
    endfunction

    // Lower start at the next falling edge and hold it low until the task returns
    task automatic hold_off(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Drive one command transaction and wait for it to be taken
    task automatic issue_item(op_t o, logic signed [cdwt_pkg::TEMP_W-1:0] t, logic v,
                              output bit produced, output excess_report_t rep);
        @(negedge clk);
        start = 1'b1;
        op = o;
        temperature = t;
        sample_valid = v;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        produced = track_window(o, t, v, rep);
    endtask

    // Wait for every pending report, then let the block settle
    task automatic drain_reports();
        hold_off(1);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_ref_temp(logic signed [cdwt_pkg::TEMP_W-1:0] value);
        drain_reports();
        cfg_valid = 1'b1;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_ref = value;
        ref_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic push_row(row_kind_t k, op_t o, int t, bit v, int n, bit typed = 1'b0,
                            int ex = 0, longint tot = 0, int lo = 0, int hi = 0);
        stim_row_t row;
        row.kind = k;
        row.op = o;
        row.temp = cdwt_pkg::TEMP_W'(t);
        row.valid = v;
        row.reps = n;
        row.typed = typed;
        row.want.excess = cdwt_pkg::EXCESS_W'(ex);
        row.want.total = cdwt_pkg::TOTAL_W'(tot);
        row.want.lo = cdwt_pkg::TEMP_W'(lo);
        row.want.hi = cdwt_pkg::TEMP_W'(hi);
        directed_rows.push_back(row);
    endtask

    initial
    begin
        excess_report_t                         rep;
        bit                                     produced;
        logic signed [cdwt_pkg::TEMP_W-1:0]     ref_plan [PHASES];
        int                                     idle_pct;
        int                                     counted;
        int                                     centre;
        int                                     spread;
        int                                     band_left;
        int                                     pick;
        int                                     t;
        bit                                     paused;
        op_t                                    o;
        logic                                   v;

        // Hold reset low, then release it at a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: reset reference first
        push_row(ROW_ITEM, OP_EVAL, 0, 1'b1, 1);          // empty window: no report
        push_row(ROW_ITEM, OP_STORE, 1023, 1'b0, 1);      // invalid sample dropped
        push_row(ROW_ITEM, OP_STORE, 300, 1'b1, WINDOW - 1);
        push_row(ROW_ITEM, OP_EVAL, -1, 1'b0, 1);         // one short of full: no report
        push_row(ROW_ITEM, OP_STORE, 300, 1'b1, 1);       // first wrap fills the window
        push_row(ROW_ITEM, OP_EVAL, 0, 1'b0, 1, 1'b1, 80, 80, 300, 300);
        push_row(ROW_ITEM, OP_STORE, -1024, 1'b1, 1);
        push_row(ROW_ITEM, OP_STORE, 1023, 1'b1, 1);
        push_row(ROW_ITEM, OP_STORE, -1024, 1'b0, 1);     // invalid, window unchanged
        push_row(ROW_ITEM, OP_EVAL, 0, 1'b0, 1, 1'b1, 0, 80, -1024, 1023);
        // Lowest reference with a window of highest samples gives the largest excess
        push_row(ROW_REF, OP_STORE, -1024, 1'b0, 1);
        push_row(ROW_ITEM, OP_STORE, 1023, 1'b1, WINDOW);
        push_row(ROW_ITEM, OP_EVAL, 0, 1'b0, 1, 1'b1, 4094, 4174, 1023, 1023);
        // Sample fields on an evaluation are ignored
        push_row(ROW_ITEM, OP_EVAL, -1024, 1'b1, 1, 1'b1, 4094, 8268, 1023, 1023);
        push_row(ROW_REF, OP_STORE, 1023, 1'b0, 1);
        push_row(ROW_ITEM, OP_STORE, -1024, 1'b1, WINDOW);
        push_row(ROW_ITEM, OP_EVAL, 0, 1'b0, 1, 1'b1, 0, 8268, -1024, -1024);
        push_row(ROW_REF, OP_STORE, cdwt_pkg::REF_RESET, 1'b0, 1);
        push_row(ROW_ITEM, OP_STORE, 750, 1'b1, WINDOW - 2);
        push_row(ROW_ITEM, OP_STORE, 800, 1'b1, 1);
        push_row(ROW_ITEM, OP_STORE, 410, 1'b1, 1);
        push_row(ROW_ITEM, OP_EVAL, 0, 1'b0, 1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REF)
                write_ref_temp(directed_rows[i].temp);
            else
                repeat (directed_rows[i].reps)
                begin
                    issue_item(directed_rows[i].op, directed_rows[i].temp,
                               directed_rows[i].valid, produced, rep);
                    if (produced)
                        pending_reports.push_back(directed_rows[i].typed ?
                                                  directed_rows[i].want : rep);
                end
        end

        // Random phases, one reference setting each
        ref_plan[0] = cdwt_pkg::TEMP_NEG_MIN;
        ref_plan[1] = cdwt_pkg::REF_RESET;
        ref_plan[2] = cdwt_pkg::TEMP_POS_MAX;
        ref_plan[3] = '0;
        ref_plan[4] = cdwt_pkg::TEMP_W'(int'($urandom_range(0, 1200)) - 400);
        ref_plan[5] = cdwt_pkg::TEMP_W'($urandom_range(0, 2047));
        band_left = 0;
        centre = 0;
        spread = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_ref_temp(ref_plan[phase]);
            case (phase % 4)
                1: idle_pct = 60;
                3: idle_pct = 36;
                default: idle_pct = 0;
            endcase
            counted = 0;
            paused = 1'b0;
            while (counted < PHASE_ITEMS)
            begin
                // Drift the temperature band so the excess varies
                if (band_left == 0)
                begin
                    centre = int'($urandom_range(0, 1200)) - 400;
                    spread = $urandom_range(0, 150);
                    band_left = $urandom_range(20, 150);
                end
                band_left--;
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 3)
                    t = $urandom_range(0, 2047);
                else
                    t = centre + int'($urandom_range(0, spread)) - spread / 2;
                v = 1'b1;
                o = OP_STORE;
                if (pick < 14)
                begin
                    o = OP_EVAL;
                    v = 1'($urandom_range(0, 1));
                    t = $urandom_range(0, 2047);
                end
                else if (pick < 22)
                begin
                    v = 1'b0;
                    t = $urandom_range(0, 2047);
                end
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    hold_off($urandom_range(1, 6));
                issue_item(o, cdwt_pkg::TEMP_W'(t), v, produced, rep);
                if (produced)
                    pending_reports.push_back(rep);
                if (produced || (o == OP_STORE && v))
                    counted++;
                // On odd phases, hold off mid-phase until all reports are home
                if (phase % 2 == 1 && !paused && counted >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    hold_off(1);
                    while (pending_reports.size() != 0)
                        @(posedge clk);
                end
            end
        end

        hold_off(1);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d command transactions, %0d evaluation reports checked",
                 items_sent, reports_checked);
        $display("across %0d reference writes including both extremes; %0d mismatches",
                 ref_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
